// ===== hw/rtl/qrs_pkg.sv =====
// qrs_pkg: widths, result codes and pipeline stage records for the quadratic root solver
// used by quadratic_root_solver and its checker; no dependencies
package qrs_pkg;

  // field widths
  localparam int CW   = 16;  // coefficient width, signed Q8.8
  localparam int RW   = 32;  // result width, signed Q16.16
  localparam int DQW  = 35;  // signed discriminant
  localparam int DAW  = 34;  // discriminant magnitude
  localparam int SW   = 32;  // square root result
  localparam int RMW  = 36;  // square root partial remainder
  localparam int NW   = 35;  // signed numerator
  localparam int DVW  = 36;  // dividend and quotient
  localparam int DSW  = 17;  // divisor (twice |a|)
  localparam int SQ_STAGES  = SW;
  localparam int DIV_STAGES = DVW;

  // root kind codes
  localparam logic [1:0] KIND_REPEAT  = 2'd0;
  localparam logic [1:0] KIND_COMPLEX = 2'd1;
  localparam logic [1:0] KIND_REAL    = 2'd2;
  localparam logic [1:0] KIND_ZERO_A  = 2'd3;

  // square root stage record
  typedef struct packed {
    logic [1:0]     kind;
    logic [CW-1:0]  a;
    logic [31:0]    nb;
    logic [DAW-1:0] dabs;
    logic [SW-1:0]  root;
    logic [RMW-1:0] rem;
  } sq_t;

  // numerator stage record
  typedef struct packed {
    logic [1:0]    kind;
    logic [CW-1:0] a;
    logic [NW-1:0] n1;
    logic [NW-1:0] n2;
  } num_t;

  // divider stage record, two dividers side by side
  typedef struct packed {
    logic [1:0]     kind;
    logic           neg1;
    logic           neg2;
    logic [DSW-1:0] dvs;
    logic [DVW-1:0] w1;
    logic [DSW-1:0] r1;
    logic [DVW-1:0] w2;
    logic [DSW-1:0] r2;
  } div_t;

endpackage

// ===== hw/rtl/quadratic_root_solver.sv =====
// quadratic_root_solver: pipelined roots of a*x^2+b*x+c, Q8.8 in, Q16.16 out
// depends on qrs_pkg
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_stall   | in_coef_a, in_coef_b, in_coef_c
//  out_    | output    | out_valid/out_stall | out_root_kind, out_first_value,
//          |           |                     | out_second_value, out_saturated
//
// one transaction per cycle unless an untaken result stalls the output
// the depth is set by the 32-stage square root and the 36-stage dividers, one bit per stage
// synchronous active-low reset clears only the stage valid bits
// a stalled output freezes the whole pipeline; nothing is lost or repeated
module quadratic_root_solver (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [qrs_pkg::CW-1:0] in_coef_a,
  input  logic [qrs_pkg::CW-1:0] in_coef_b,
  input  logic [qrs_pkg::CW-1:0] in_coef_c,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_root_kind,
  output logic [qrs_pkg::RW-1:0] out_first_value,
  output logic [qrs_pkg::RW-1:0] out_second_value,
  output logic                   out_saturated
);

  localparam int CW = qrs_pkg::CW;

  logic adv;

  // pipeline advances unless the output holds an untaken result
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 0: input capture
  logic          v0_r;
  logic [CW-1:0] a0_r, b0_r, c0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r <= in_coef_a;
      b0_r <= in_coef_b;
      c0_r <= in_coef_c;
    end
  end

  // stage 1: products
  logic          v1_r;
  logic [31:0]   bb_r, ac_r, nb_r;
  logic [CW-1:0] a1_r;
  logic [31:0]   bb_nxt, ac_nxt, nb_nxt;
  logic [16:0]   negb;

  always_comb begin
    bb_nxt = 32'($signed(b0_r) * $signed(b0_r));
    ac_nxt = 32'($signed(a0_r) * $signed(c0_r));
    negb   = 17'(-$signed({b0_r[CW-1], b0_r}));
    nb_nxt = {negb, 15'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bb_r <= bb_nxt;
      ac_r <= ac_nxt;
      nb_r <= nb_nxt;
      a1_r <= a0_r;
    end
  end

  // stage 2: discriminant and kind
  logic [qrs_pkg::DQW-1:0] dq;
  qrs_pkg::sq_t            sq_nxt;

  always_comb begin
    dq = qrs_pkg::DQW'($signed(bb_r)) - (qrs_pkg::DQW'($signed(ac_r)) <<< 2);
    sq_nxt      = '0;
    sq_nxt.a    = a1_r;
    sq_nxt.nb   = nb_r;
    sq_nxt.dabs = qrs_pkg::DAW'(dq[qrs_pkg::DQW-1] ? -dq : dq);
    if (a1_r == '0) begin
      sq_nxt.kind = qrs_pkg::KIND_ZERO_A;
    end else if (dq == '0) begin
      sq_nxt.kind = qrs_pkg::KIND_REPEAT;
    end else if (dq[qrs_pkg::DQW-1]) begin
      sq_nxt.kind = qrs_pkg::KIND_COMPLEX;
    end else begin
      sq_nxt.kind = qrs_pkg::KIND_REAL;
    end
  end

  // square root pipeline, one result bit per stage
  logic         sq_v_r [0:qrs_pkg::SQ_STAGES];
  qrs_pkg::sq_t sq_r   [0:qrs_pkg::SQ_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= sq_nxt;
    end
  end

  for (genvar j = 0; j < qrs_pkg::SQ_STAGES; j++) begin : g_sqrt
    localparam int PI = qrs_pkg::SQ_STAGES - 1 - j;
    logic [63:0]              x;
    logic [1:0]               pair;
    logic [qrs_pkg::RMW-1:0]  rsh, trial;
    qrs_pkg::sq_t             st_nxt;

    // restoring step on the next bit pair of |dq| * 2^30
    always_comb begin
      x      = {sq_r[j].dabs, 30'b0};
      pair   = x[2*PI+1 -: 2];
      rsh    = {sq_r[j].rem[qrs_pkg::RMW-3:0], pair};
      trial  = qrs_pkg::RMW'({sq_r[j].root, 2'b01});
      st_nxt = sq_r[j];
      if (rsh >= trial) begin
        st_nxt.rem  = rsh - trial;
        st_nxt.root = {sq_r[j].root[qrs_pkg::SW-2:0], 1'b1};
      end else begin
        st_nxt.rem  = rsh;
        st_nxt.root = {sq_r[j].root[qrs_pkg::SW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[j+1] <= st_nxt;
      end
    end
  end

  // numerator selection by kind
  localparam int NW = qrs_pkg::NW;
  qrs_pkg::sq_t  sq_last;
  logic [NW-1:0] nb35, s35;
  qrs_pkg::num_t num_nxt, num_r;
  logic          num_v_r;

  always_comb begin
    sq_last      = sq_r[qrs_pkg::SQ_STAGES];
    nb35         = NW'($signed(sq_last.nb));
    s35          = NW'(sq_last.root);
    num_nxt.kind = sq_last.kind;
    num_nxt.a    = sq_last.a;
    case (sq_last.kind)
      qrs_pkg::KIND_REAL: begin
        num_nxt.n1 = nb35 - s35;
        num_nxt.n2 = nb35 + s35;
      end
      qrs_pkg::KIND_COMPLEX: begin
        num_nxt.n1 = nb35;
        num_nxt.n2 = s35;
      end
      default: begin
        num_nxt.n1 = nb35;
        num_nxt.n2 = nb35;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_v_r <= 1'b0;
    end else if (adv) begin
      num_v_r <= sq_v_r[qrs_pkg::SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_nxt;
    end
  end

  // divider setup: magnitudes, rounding offset and signs
  localparam int DVW = qrs_pkg::DVW;
  localparam int DSW = qrs_pkg::DSW;
  logic [CW-1:0]  ud;
  logic [NW-1:0]  un1, un2;
  qrs_pkg::div_t  dv_nxt;

  always_comb begin
    ud          = num_r.a[CW-1] ? -num_r.a : num_r.a;
    un1         = num_r.n1[NW-1] ? -num_r.n1 : num_r.n1;
    un2         = num_r.n2[NW-1] ? -num_r.n2 : num_r.n2;
    dv_nxt.kind = num_r.kind;
    dv_nxt.neg1 = num_r.n1[NW-1] ^ num_r.a[CW-1];
    dv_nxt.neg2 = num_r.n2[NW-1] ^ num_r.a[CW-1];
    dv_nxt.dvs  = {ud, 1'b0};
    dv_nxt.w1   = DVW'({un1, 1'b0}) + DVW'(ud);
    dv_nxt.w2   = DVW'({un2, 1'b0}) + DVW'(ud);
    dv_nxt.r1   = '0;
    dv_nxt.r2   = '0;
  end

  // restoring dividers, one quotient bit per stage
  logic          dv_v_r [0:qrs_pkg::DIV_STAGES];
  qrs_pkg::div_t dv_r   [0:qrs_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= num_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dv_nxt;
    end
  end

  for (genvar k = 0; k < qrs_pkg::DIV_STAGES; k++) begin : g_div
    logic [DSW:0]  t1, t2, dv_ext;
    qrs_pkg::div_t st_nxt;

    always_comb begin
      dv_ext = {1'b0, dv_r[k].dvs};
      t1     = {dv_r[k].r1, dv_r[k].w1[DVW-1]};
      t2     = {dv_r[k].r2, dv_r[k].w2[DVW-1]};
      st_nxt = dv_r[k];
      if (t1 >= dv_ext) begin
        st_nxt.r1 = DSW'(t1 - dv_ext);
        st_nxt.w1 = {dv_r[k].w1[DVW-2:0], 1'b1};
      end else begin
        st_nxt.r1 = DSW'(t1);
        st_nxt.w1 = {dv_r[k].w1[DVW-2:0], 1'b0};
      end
      if (t2 >= dv_ext) begin
        st_nxt.r2 = DSW'(t2 - dv_ext);
        st_nxt.w2 = {dv_r[k].w2[DVW-2:0], 1'b1};
      end else begin
        st_nxt.r2 = DSW'(t2);
        st_nxt.w2 = {dv_r[k].w2[DVW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= st_nxt;
      end
    end
  end

  // sign, saturation and output register
  localparam int RW = qrs_pkg::RW;
  localparam logic signed [DVW:0] VMAX = DVW'(1) <<< (RW - 1);
  qrs_pkg::div_t        dv_last;
  logic signed [DVW:0]  v1, v2;
  logic                 sat1, sat2;
  logic [RW-1:0]        f1, f2;
  logic                 out_valid_r, sat_r;
  logic [1:0]           kind_r;
  logic [RW-1:0]        first_r, second_r;

  always_comb begin
    dv_last = dv_r[qrs_pkg::DIV_STAGES];
    v1   = dv_last.neg1 ? -$signed({1'b0, dv_last.w1}) : $signed({1'b0, dv_last.w1});
    v2   = dv_last.neg2 ? -$signed({1'b0, dv_last.w2}) : $signed({1'b0, dv_last.w2});
    sat1 = (v1 > VMAX - 1) || (v1 < -VMAX);
    sat2 = (v2 > VMAX - 1) || (v2 < -VMAX);
    f1   = !sat1 ? RW'(v1) : (v1[DVW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}});
    f2   = !sat2 ? RW'(v2) : (v2[DVW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[qrs_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= dv_last.kind;
      if (dv_last.kind == qrs_pkg::KIND_ZERO_A) begin
        first_r  <= '0;
        second_r <= '0;
        sat_r    <= 1'b0;
      end else begin
        first_r  <= f1;
        second_r <= f2;
        sat_r    <= sat1 || sat2;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_root_kind    = kind_r;
  assign out_first_value  = first_r;
  assign out_second_value = second_r;
  assign out_saturated    = sat_r;

endmodule

// ===== hw/rtl/qrs_checker.sv =====
// qrs_checker: port-level assertions for quadratic_root_solver, bound to the top level
// depends on qrs_pkg
module qrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_root_kind,
  input logic [31:0] out_first_value,
  input logic [31:0] out_second_value,
  input logic        out_saturated
);

  // a result waiting on a stall stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  // input is back-pressured only by an untaken result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without output stall");

  // zero a gives cleared fields
  a_zero_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == qrs_pkg::KIND_ZERO_A |->
      out_first_value == '0 && out_second_value == '0 && !out_saturated)
    else $error("zero a transaction with nonzero fields");

  // repeated root reports the same value twice
  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == qrs_pkg::KIND_REPEAT |->
      out_first_value == out_second_value)
    else $error("repeated root values differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_root_kind    (out_root_kind),
  .out_first_value  (out_first_value),
  .out_second_value (out_second_value),
  .out_saturated    (out_saturated)
);
